// ===== design/fws_pkg.sv =====
// Shared types and constants for the weighted sampler.
package fws_pkg;

   localparam int INDEX_W     = 10;
   localparam int WEIGHT_IN_W = 32;
   localparam int FRAC_W      = 32;
   localparam int TOTAL_W     = 42;

   localparam logic KIND_SET    = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef struct packed {
      logic                   kind;
      logic [INDEX_W-1:0]     entry_index;
      logic [WEIGHT_IN_W-1:0] new_weight;
      logic [FRAC_W-1:0]      random_fraction;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] sampled_index;
      logic [TOTAL_W-1:0] total_weight;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic set_read;
      logic set_diff;
      logic set_walk;
      logic smp_mul;
      logic smp_sum;
      logic smp_walk;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic in_range;
      logic walk_last;
      logic step_last;
   } status_type;

endpackage

// ===== design/fenwick_weighted_sampler.sv =====
// Top level of the Fenwick-tree weighted sampler.
//
// A request transaction either sets one weight (kind = set) or draws one entry
// with probability proportional to its weight (kind = sample). Every request
// returns exactly one response transaction carrying the total weight after the
// request, plus the drawn entry for a sample (zero for a set).
// Requests are processed one at a time. The tree memory has one read port, so
// the tree nodes on a path are read one after another:
//   sample: a threshold multiply and sum, log2(TABLE_SIZE)+1 descent steps,
//           then the result step,
//   set: a weight read, a difference step, then one step per node on the
//        update path; the walk is skipped when the entry index is past the table.
// rsp_valid rises as the block returns to idle, in the same cycle the next
// request can be accepted. The response sits in an output register; a new
// request is taken while it waits. If the receiver stalls, the finished result
// of the next request holds inside the block until the register frees.
// After reset the block clears both memories, one entry per cycle, with
// req_stall high throughout.
module fenwick_weighted_sampler #(
   parameter int TABLE_SIZE  = 1024,
   parameter int WEIGHT_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fws_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fws_pkg::rsp_type rsp_payload
);
   import fws_pkg::*;

   cmd_type    cmd;
   status_type status;

   fws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_payload.kind),
      .rsp_stall (rsp_stall),
      .status    (status),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   fws_datapath #(
      .TABLE_SIZE  (TABLE_SIZE),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   // One transaction in flight: an accepted request blocks the next cycle.
   a_accept_blocks : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one still in progress");

   // The drawn entry always lies inside the table.
   a_index_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_payload.sampled_index) < 32'(TABLE_SIZE)))
      else $error("sampled index outside the table");

   // Memory clearing follows reset before any request is taken.
   a_clear_after_reset : assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall)
      else $error("request port open before memory clear");

endmodule

// ===== design/fws_datapath.sv =====
// Datapath: weight and tree memories, update walk, threshold multiply and descent.
module fws_datapath #(
   parameter int TABLE_SIZE  = 1024,
   parameter int WEIGHT_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  fws_pkg::req_type    req_payload,
   input  fws_pkg::cmd_type    cmd,
   output fws_pkg::status_type status,
   output fws_pkg::rsp_type    rsp_payload
);
   import fws_pkg::*;

   localparam int AW      = $clog2(TABLE_SIZE);
   localparam int NODE_W  = $clog2(TABLE_SIZE + 1) + 1;
   localparam int LOG_TOP = $clog2(TABLE_SIZE + 1) - 1;
   localparam logic [NODE_W-1:0] SIZE_NODE  = NODE_W'(TABLE_SIZE);
   localparam logic [NODE_W-1:0] TOP_NODE   = NODE_W'(1) << LOG_TOP;
   localparam logic [AW-1:0]     LAST_ADDR  = AW'(TABLE_SIZE - 1);
   localparam logic [47:0]       WEIGHT_MAX = (48'(1) << WEIGHT_BITS) - 48'(1);

   function automatic logic [NODE_W-1:0] low_bit(input logic [NODE_W-1:0] n);
      return n & (~n + NODE_W'(1));
   endfunction

   // Tree node n lives at address n-1; nodes past the table map to address zero.
   function automatic logic [AW-1:0] node_addr(input logic [NODE_W-1:0] n);
      logic [NODE_W-1:0] m;
      m = n - NODE_W'(1);
      return (n > SIZE_NODE || n == '0) ? '0 : AW'(m);
   endfunction

   logic [WEIGHT_BITS-1:0] weight_mem [TABLE_SIZE];
   logic [TOTAL_W-1:0]     tree_mem   [TABLE_SIZE];

   req_type                req_ff;
   rsp_type                rsp_ff;
   logic [AW-1:0]          clr_ff;
   logic [TOTAL_W-1:0]     sum_ff;
   logic [TOTAL_W-1:0]     diff_ff;
   logic [NODE_W-1:0]      node_ff;
   logic [NODE_W-1:0]      wr_node_ff;
   logic [63:0]            prod_lo_ff;
   logic [TOTAL_W-1:0]     prod_hi_ff;
   logic [TOTAL_W-1:0]     rest_ff;
   logic [NODE_W-1:0]      pos_ff;
   logic [NODE_W-1:0]      step_ff;
   logic [WEIGHT_BITS-1:0] wt_rdata_ff;
   logic [TOTAL_W-1:0]     tree_rdata_ff;

   logic                   in_range;
   logic [AW-1:0]          entry_addr;
   logic [47:0]            weight_wide;
   logic [47:0]            weight_sat;
   logic [WEIGHT_BITS-1:0] weight_new;
   logic [TOTAL_W-1:0]     diff_now;
   logic [NODE_W-1:0]      node_step;
   logic [NODE_W-1:0]      nx;
   logic                   nx_ok;
   logic                   take;
   logic [NODE_W-1:0]      pos_next;
   logic [NODE_W-1:0]      step_next;
   logic [NODE_W-1:0]      pos_clamp;

   logic                   wt_we;
   logic [AW-1:0]          wt_waddr;
   logic [WEIGHT_BITS-1:0] wt_wdata;
   logic                   tree_we;
   logic [AW-1:0]          tree_waddr;
   logic [TOTAL_W-1:0]     tree_wdata;
   logic [AW-1:0]          tree_raddr;

   assign in_range    = 32'(req_ff.entry_index) < 32'(TABLE_SIZE);
   assign entry_addr  = AW'(req_ff.entry_index);
   assign weight_wide = 48'(req_ff.new_weight);
   assign weight_sat  = (weight_wide > WEIGHT_MAX) ? WEIGHT_MAX : weight_wide;
   assign weight_new  = WEIGHT_BITS'(weight_sat);
   assign diff_now    = TOTAL_W'(weight_new) - TOTAL_W'(wt_rdata_ff);
   assign node_step   = node_ff + low_bit(node_ff);

   // Descent step: pass the node while its partial sum fits under the threshold.
   assign nx        = pos_ff + step_ff;
   assign nx_ok     = nx <= SIZE_NODE;
   assign take      = nx_ok && (tree_rdata_ff <= rest_ff);
   assign pos_next  = take ? nx : pos_ff;
   assign step_next = step_ff >> 1;
   assign pos_clamp = (pos_ff >= SIZE_NODE) ? SIZE_NODE - NODE_W'(1) : pos_ff;

   assign wt_we      = cmd.clear || cmd.set_diff;
   assign wt_waddr   = cmd.clear ? clr_ff : entry_addr;
   assign wt_wdata   = cmd.clear ? '0 : weight_new;
   assign tree_we    = cmd.clear || cmd.set_walk;
   assign tree_waddr = cmd.clear ? clr_ff : node_addr(wr_node_ff);
   assign tree_wdata = cmd.clear ? '0 : tree_rdata_ff + diff_ff;

   always_comb begin
      priority if (cmd.smp_sum) begin
         tree_raddr = node_addr(TOP_NODE);
      end else if (cmd.smp_walk) begin
         tree_raddr = node_addr(pos_next + step_next);
      end else begin
         tree_raddr = node_addr(node_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wt_we) begin
         weight_mem[wt_waddr] <= wt_wdata;
      end
      wt_rdata_ff <= weight_mem[entry_addr];
   end

   always_ff @(posedge clock) begin
      if (tree_we) begin
         tree_mem[tree_waddr] <= tree_wdata;
      end
      tree_rdata_ff <= tree_mem[tree_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         sum_ff <= '0;
      end else begin
         if (cmd.clear) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (cmd.set_diff) begin
            sum_ff <= sum_ff + diff_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
      if (cmd.set_read) begin
         node_ff <= NODE_W'(req_ff.entry_index) + NODE_W'(1);
      end
      if (cmd.set_diff) begin
         diff_ff    <= diff_now;
         wr_node_ff <= node_ff;
         node_ff    <= node_step;
      end
      // Write back the node read last cycle while the next one is read.
      if (cmd.set_walk) begin
         wr_node_ff <= node_ff;
         node_ff    <= node_step;
      end
      if (cmd.smp_mul) begin
         prod_lo_ff <= 64'(req_ff.random_fraction) * 64'(sum_ff[31:0]);
         prod_hi_ff <= TOTAL_W'(req_ff.random_fraction) * TOTAL_W'(sum_ff[TOTAL_W-1:32]);
      end
      if (cmd.smp_sum) begin
         rest_ff <= prod_hi_ff + TOTAL_W'(prod_lo_ff[63:32]);
         pos_ff  <= '0;
         step_ff <= TOP_NODE;
      end
      if (cmd.smp_walk) begin
         pos_ff  <= pos_next;
         step_ff <= step_next;
         if (take) begin
            rest_ff <= rest_ff - tree_rdata_ff;
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.sampled_index <= (req_ff.kind == KIND_SAMPLE) ? INDEX_W'(pos_clamp) : '0;
         rsp_ff.total_weight  <= sum_ff;
      end
   end

   assign status.clear_last = clr_ff == LAST_ADDR;
   assign status.in_range   = in_range;
   assign status.walk_last  = node_ff > SIZE_NODE;
   assign status.step_last  = step_ff == NODE_W'(1);
   assign rsp_payload       = rsp_ff;

endmodule

// ===== design/fws_ctrl.sv =====
// Controller: sequences clearing, weight updates, sampling and result handoff.
module fws_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   input  logic                rsp_stall,
   input  fws_pkg::status_type status,
   output logic                req_stall,
   output logic                rsp_valid,
   output fws_pkg::cmd_type    cmd
);
   import fws_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET_READ,
      ST_SET_DIFF,
      ST_SET_WALK,
      ST_SMP_MUL,
      ST_SMP_SUM,
      ST_SMP_WALK,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_kind == KIND_SAMPLE) ? ST_SMP_MUL : ST_SET_READ;
            end
         end
         ST_SET_READ: begin
            cmd.set_read = 1'b1;
            state_in     = status.in_range ? ST_SET_DIFF : ST_FINISH;
         end
         ST_SET_DIFF: begin
            cmd.set_diff = 1'b1;
            state_in     = ST_SET_WALK;
         end
         ST_SET_WALK: begin
            cmd.set_walk = 1'b1;
            if (status.walk_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_SMP_MUL: begin
            cmd.smp_mul = 1'b1;
            state_in    = ST_SMP_SUM;
         end
         ST_SMP_SUM: begin
            cmd.smp_sum = 1'b1;
            state_in    = ST_SMP_WALK;
         end
         ST_SMP_WALK: begin
            cmd.smp_walk = 1'b1;
            if (status.step_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free.
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule
